FILE: sv/ethg_pkg.sv
// Shared widths, constants and types for the event-triggered hue glide block.
`timescale 1ns / 1ps

package ethg_pkg;

    localparam int DT_W        = 18;
    localparam int SAL_W       = 16;
    localparam int HUE_W       = 8;
    localparam int TIME_W      = 24;
    localparam int FRAC_W      = 16;
    localparam int PROG_W      = FRAC_W + 1;
    localparam int DIVIDEND_W  = DT_W + FRAC_W;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 8;
    localparam int OUT_TUSER_W = 2;

    localparam logic [PROG_W-1:0] PROGRESS_ONE = PROG_W'(1) << FRAC_W;

    localparam logic [SAL_W-1:0]  THRESHOLD_RESET  = SAL_W'(19661);
    localparam logic [HUE_W-1:0]  HUE_SHIFT_RESET  = HUE_W'(32);
    localparam logic [TIME_W-1:0] COOLDOWN_RESET   = TIME_W'(500000);
    localparam logic [TIME_W-1:0] TRANSITION_RESET = TIME_W'(300000);
    localparam logic [HUE_W-1:0]  START_HUE_RESET  = HUE_W'(0);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_THRESHOLD  = 3'd0,
        REG_HUE_SHIFT  = 3'd1,
        REG_COOLDOWN   = 3'd2,
        REG_TRANSITION = 3'd3,
        REG_START_HUE  = 3'd4
    } cfg_reg_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_SQ   = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

endpackage

FILE: sv/event_triggered_hue_glide.sv
// Top level of the event-triggered hue glide block.
//
// One input item is one display frame on s_axis: tdata carries the frame time
// and the saliency level, tuser the audio-valid flag. One result item per frame
// leaves on m_axis: tdata is the current hue, tuser the event and settled flags.
// Registers are written through cfg_wr_en / cfg_addr / cfg_wdata; the user must
// write them only while idle, and the block itself does not enforce it. Writing
// start_hue loads the current and target hue at once.
// s_axis_tready is high only while no frame is in work. A gliding frame runs the
// serial divider (one quotient bit per cycle) for the progress step, then the
// progress update, the ease-out square, the hue scaling and the output load. A
// settled frame goes straight to the output load; a zero transition time skips
// the divider. The block takes no new frame until the last result is loaded.
// The result waits in an output register; a stalled receiver holds the block in
// its last step until that register is free. Reset restores the register
// defaults, sets the hues to the start hue and marks the glide as settled; no
// clearing pass is needed.
`timescale 1ns / 1ps

module event_triggered_hue_glide (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [ethg_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [ethg_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // frame_dt_us [17:0], saliency_level [33:18], zero fill [39:34]
    input  logic [ethg_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // audio_valid [0]
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // hue_now [7:0]
    output logic [ethg_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // event_fired [0], settled [1]
    output logic [ethg_pkg::OUT_TUSER_W-1:0]    m_axis_tuser
);
    import ethg_pkg::*;

    state_t state_reg, state_next;

    logic [SAL_W-1:0]  threshold_reg, threshold_next;
    logic [HUE_W-1:0]  shift_reg, shift_next;
    logic [TIME_W-1:0] cooldown_time_reg, cooldown_time_next;
    logic [TIME_W-1:0] transition_reg, transition_next;
    logic [HUE_W-1:0]  start_hue_reg, start_hue_next;

    logic [HUE_W-1:0]  hue_cur_reg, hue_cur_next;
    logic [HUE_W-1:0]  hue_tgt_reg, hue_tgt_next;
    logic [PROG_W-1:0] progress_reg, progress_next;
    logic [SAL_W-1:0]  prev_sal_reg, prev_sal_next;
    logic [TIME_W-1:0] cooldown_reg, cooldown_next;

    logic              fired_reg, fired_next;
    logic [PROG_W-1:0] eased_reg, eased_next;
    logic              out_valid_reg, out_valid_next;
    logic [HUE_W-1:0]  out_hue_reg, out_hue_next;
    logic              out_fired_reg, out_fired_next;
    logic              out_settled_reg, out_settled_next;

    logic [DT_W-1:0]       in_dt;
    logic [SAL_W-1:0]      in_sal;
    logic                  in_accept;
    logic [TIME_W-1:0]     cool_dec;
    logic                  rising;
    logic                  fire;
    logic [PROG_W-1:0]     progress_acc;
    logic                  div_start;
    logic                  div_done;
    logic [DIVIDEND_W-1:0] div_quotient;
    logic [DIVIDEND_W:0]   prog_sum;
    logic [PROG_W-1:0]     rem;
    logic [2*PROG_W-1:0]   rem_sq;
    logic [PROG_W:0]       eased_wide;
    logic [HUE_W-1:0]      hue_diff;
    logic [HUE_W-1:0]      diff_mag;
    logic [HUE_W+PROG_W-1:0] scaled;
    logic [HUE_W-1:0]      step_mag;
    logic [HUE_W-1:0]      hue_step;
    logic                  out_free;

    assign in_dt     = s_axis_tdata[DT_W-1:0];
    assign in_sal    = s_axis_tdata[DT_W+SAL_W-1:DT_W];
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;

    assign cool_dec = (cooldown_reg > TIME_W'(in_dt)) ? cooldown_reg - TIME_W'(in_dt) : '0;
    assign rising   = (in_sal > threshold_reg) && (prev_sal_reg <= threshold_reg);
    assign fire     = s_axis_tuser && rising && (cool_dec == '0);
    assign progress_acc = fire ? '0 : progress_reg;

    assign div_start = in_accept && (progress_acc < PROGRESS_ONE) && (transition_reg != '0);

    assign prog_sum   = {{(DIVIDEND_W+1-PROG_W){1'b0}}, progress_reg}
                        + {1'b0, div_quotient};
    assign rem        = PROGRESS_ONE - progress_reg;
    assign rem_sq     = (2*PROG_W)'(rem) * (2*PROG_W)'(rem);
    assign eased_wide = {1'b0, PROGRESS_ONE} - rem_sq[2*PROG_W-1:FRAC_W];
    assign hue_diff   = hue_tgt_reg - hue_cur_reg;
    assign diff_mag   = hue_diff[HUE_W-1] ? HUE_W'(0) - hue_diff : hue_diff;
    assign scaled     = (HUE_W+PROG_W)'(diff_mag) * (HUE_W+PROG_W)'(eased_reg);
    assign step_mag   = scaled[FRAC_W+HUE_W-1:FRAC_W];
    assign hue_step   = hue_diff[HUE_W-1] ? HUE_W'(0) - step_mag : step_mag;

    ethg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({in_dt, {FRAC_W{1'b0}}}),
        .divisor  (transition_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        state_next         = state_reg;
        threshold_next     = threshold_reg;
        shift_next         = shift_reg;
        cooldown_time_next = cooldown_time_reg;
        transition_next    = transition_reg;
        start_hue_next     = start_hue_reg;
        hue_cur_next       = hue_cur_reg;
        hue_tgt_next       = hue_tgt_reg;
        progress_next      = progress_reg;
        prev_sal_next      = prev_sal_reg;
        cooldown_next      = cooldown_reg;
        fired_next         = fired_reg;
        eased_next         = eased_reg;
        out_valid_next     = out_valid_reg;
        out_hue_next       = out_hue_reg;
        out_fired_next     = out_fired_reg;
        out_settled_next   = out_settled_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    cooldown_next = cool_dec;
                    fired_next    = fire;
                    if (s_axis_tuser)
                    begin
                        prev_sal_next = in_sal;
                    end
                    if (fire)
                    begin
                        hue_tgt_next  = hue_cur_reg + shift_reg;
                        cooldown_next = cooldown_time_reg;
                    end
                    progress_next = progress_acc;
                    if (progress_acc < PROGRESS_ONE)
                    begin
                        if (transition_reg == '0)
                        begin
                            progress_next = PROGRESS_ONE;
                            state_next    = ST_SQ;
                        end
                        else
                        begin
                            state_next = ST_DIV;
                        end
                    end
                    else
                    begin
                        hue_cur_next = hue_tgt_reg;
                        state_next   = ST_DONE;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (prog_sum > (DIVIDEND_W+1)'(PROGRESS_ONE))
                    begin
                        progress_next = PROGRESS_ONE;
                    end
                    else
                    begin
                        progress_next = prog_sum[PROG_W-1:0];
                    end
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                eased_next = eased_wide[PROG_W-1:0];
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                hue_cur_next = hue_cur_reg + hue_step;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_hue_next     = hue_cur_reg;
                    out_fired_next   = fired_reg;
                    out_settled_next = progress_reg >= PROGRESS_ONE;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_THRESHOLD:  threshold_next     = cfg_wdata[SAL_W-1:0];
                REG_HUE_SHIFT:  shift_next         = cfg_wdata[HUE_W-1:0];
                REG_COOLDOWN:   cooldown_time_next = cfg_wdata[TIME_W-1:0];
                REG_TRANSITION: transition_next    = cfg_wdata[TIME_W-1:0];
                REG_START_HUE:
                begin
                    start_hue_next = cfg_wdata[HUE_W-1:0];
                    hue_cur_next   = cfg_wdata[HUE_W-1:0];
                    hue_tgt_next   = cfg_wdata[HUE_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            threshold_reg     <= THRESHOLD_RESET;
            shift_reg         <= HUE_SHIFT_RESET;
            cooldown_time_reg <= COOLDOWN_RESET;
            transition_reg    <= TRANSITION_RESET;
            start_hue_reg     <= START_HUE_RESET;
            hue_cur_reg       <= START_HUE_RESET;
            hue_tgt_reg       <= START_HUE_RESET;
            progress_reg      <= PROGRESS_ONE;
            prev_sal_reg      <= '0;
            cooldown_reg      <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            threshold_reg     <= threshold_next;
            shift_reg         <= shift_next;
            cooldown_time_reg <= cooldown_time_next;
            transition_reg    <= transition_next;
            start_hue_reg     <= start_hue_next;
            hue_cur_reg       <= hue_cur_next;
            hue_tgt_reg       <= hue_tgt_next;
            progress_reg      <= progress_next;
            prev_sal_reg      <= prev_sal_next;
            cooldown_reg      <= cooldown_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fired_reg       <= fired_next;
        eased_reg       <= eased_next;
        out_hue_reg     <= out_hue_next;
        out_fired_reg   <= out_fired_next;
        out_settled_reg <= out_settled_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_hue_reg;
    assign m_axis_tuser  = {out_settled_reg, out_fired_reg};

endmodule

FILE: sv/ethg_div.sv
// Serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module ethg_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [ethg_pkg::DIVIDEND_W-1:0]    dividend,
    input  logic [ethg_pkg::TIME_W-1:0]        divisor,
    output logic                               done,
    output logic [ethg_pkg::DIVIDEND_W-1:0]    quotient
);
    import ethg_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [TIME_W-1:0]     rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [TIME_W-1:0]     div_reg, div_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [TIME_W:0]       trial;
    logic [TIME_W:0]       diff;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff      = trial - {1'b0, div_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
            cnt_next  = CNT_W'(DIVIDEND_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = diff[TIME_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[TIME_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: sv/ethg_checker.sv
// Port-level checks for the hue glide block, bound to its top level.
`timescale 1ns / 1ps

module ethg_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [ethg_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [ethg_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
    import ethg_pkg::*;

    // a frame in work blocks the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready while a frame is in work");

    // a result is posted as the block returns to idle from its last step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready && !$past(s_axis_tready))
    else $error("result posted outside the final step");

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind event_triggered_hue_glide ethg_checker u_ethg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: bench/tb_top.sv
// Testbench for the event-triggered hue glide block: scoreboard, stimulus and checks.
`timescale 1ns / 1ps

module tb_top;
    import ethg_pkg::*;

    localparam int PHASE_ITEMS = 244;
    localparam int ADDR_TOP    = (1 << CFG_ADDR_W) - 1;
    localparam int HUE_SPAN    = 1 << HUE_W;
    localparam int HUE_HALF    = HUE_SPAN / 2;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic             fired;
        logic             settled;
    } glide_result_t;

    class glide_scoreboard;
        logic [SAL_W-1:0]  thresh;
        logic [HUE_W-1:0]  shift;
        logic [TIME_W-1:0] cooldown_time;
        logic [TIME_W-1:0] glide_time;
        logic [HUE_W-1:0]  hue_cur;
        logic [HUE_W-1:0]  hue_tgt;
        logic [PROG_W-1:0] progress;
        logic [SAL_W-1:0]  last_sal;
        logic [TIME_W-1:0] cooldown_left;
        glide_result_t     expected_q[$];
        int                mismatches;

        function new();
            thresh        = THRESHOLD_RESET;
            shift         = HUE_SHIFT_RESET;
            cooldown_time = COOLDOWN_RESET;
            glide_time    = TRANSITION_RESET;
            hue_cur       = START_HUE_RESET;
            hue_tgt       = START_HUE_RESET;
            progress      = PROGRESS_ONE;
            last_sal      = '0;
            cooldown_left = '0;
            mismatches    = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
            case (addr)
                REG_THRESHOLD:  thresh = data[SAL_W-1:0];
                REG_HUE_SHIFT:  shift = data[HUE_W-1:0];
                REG_COOLDOWN:   cooldown_time = data[TIME_W-1:0];
                REG_TRANSITION: glide_time = data[TIME_W-1:0];
                REG_START_HUE:
                begin
                    hue_cur = data[HUE_W-1:0];
                    hue_tgt = data[HUE_W-1:0];
                end
                default: ;
            endcase
        endfunction

        function void note_frame(logic [DT_W-1:0] dt, logic valid, logic [SAL_W-1:0] sal);
            logic [DIVIDEND_W:0]   p;
            logic [PROG_W-1:0]     rem;
            logic [2*PROG_W-1:0]   rem_sq;
            logic [PROG_W-1:0]     eased;
            int                    diff;
            int                    mag;
            glide_result_t         res;
            res.fired = 1'b0;
            if (cooldown_left > TIME_W'(dt))
                cooldown_left = cooldown_left - TIME_W'(dt);
            else
                cooldown_left = '0;
            if (valid)
            begin
                if (sal > thresh && last_sal <= thresh && cooldown_left == '0)
                begin
                    hue_tgt       = hue_cur + shift;
                    progress      = '0;
                    cooldown_left = cooldown_time;
                    res.fired     = 1'b1;
                end
                last_sal = sal;
            end
            if (progress < PROGRESS_ONE)
            begin
                if (glide_time == '0)
                    p = (DIVIDEND_W+1)'(PROGRESS_ONE);
                else
                    p = (DIVIDEND_W+1)'(progress)
                        + (DIVIDEND_W+1)'({dt, {FRAC_W{1'b0}}} / glide_time);
                if (p > (DIVIDEND_W+1)'(PROGRESS_ONE))
                    p = (DIVIDEND_W+1)'(PROGRESS_ONE);
                progress = p[PROG_W-1:0];
                rem      = PROGRESS_ONE - progress;
                rem_sq   = (2*PROG_W)'(rem) * (2*PROG_W)'(rem);
                eased    = PROGRESS_ONE - PROG_W'(rem_sq >> FRAC_W);
                diff     = int'(hue_tgt) - int'(hue_cur);
                if (diff >= HUE_HALF)
                    diff = diff - HUE_SPAN;
                if (diff < -HUE_HALF)
                    diff = diff + HUE_SPAN;
                mag     = ((diff < 0 ? -diff : diff) * int'(eased)) >>> FRAC_W;
                hue_cur = hue_cur + HUE_W'(diff < 0 ? -mag : mag);
            end
            else
                hue_cur = hue_tgt;
            res.hue     = hue_cur;
            res.settled = (progress >= PROGRESS_ONE);
            expected_q.push_back(res);
        endfunction

        function void report(string what, glide_result_t want, glide_result_t got);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%s: expected hue %0d event %0b settled %0b, got hue %0d event %0b settled %0b",
                         what, want.hue, want.fired, want.settled, got.hue, got.fired, got.settled);
        endfunction

        function void check_result(glide_result_t got);
            glide_result_t want;
            if (expected_q.size() == 0)
            begin
                report("unexpected item", '0, got);
                return;
            end
            want = expected_q.pop_front();
            if (got.hue !== want.hue || got.fired !== want.fired || got.settled !== want.settled)
                report("mismatch", want, got);
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;

    glide_scoreboard sb = new();
    glide_result_t   seen;
    bit              calm = 1'b0;
    bit              hold_long = 1'b0;

    event_triggered_hue_glide uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_wr_en)
                sb.write_reg(cfg_addr, cfg_wdata);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_frame(s_axis_tdata[DT_W-1:0], s_axis_tuser,
                              s_axis_tdata[DT_W +: SAL_W]);
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen.hue     = m_axis_tdata;
                seen.fired   = m_axis_tuser[0];
                seen.settled = m_axis_tuser[1];
                sb.check_result(seen);
            end
        end
    end

    // receiver: random stalls, one long hold on request, none once calm
    initial
    begin
        forever
        begin
            if (hold_long)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_long = 1'b0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                repeat (calm ? 1 : $urandom_range(1, 60)) @(posedge clk);
            end
        end
    end

    task automatic send_frame(input logic [DT_W-1:0] dt, input logic valid,
                              input logic [SAL_W-1:0] sal);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'({sal, dt});
        s_axis_tuser  <= valid;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic pause_sender(input int cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // hold until every expected item is back and the block is idle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    task automatic end_writes();
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_glide_regs(input int thr, input int shift, input int cool,
                                  input int glide, input int hue);
        drain();
        write_reg(REG_THRESHOLD, CFG_DATA_W'(thr));
        write_reg(REG_HUE_SHIFT, CFG_DATA_W'(shift));
        write_reg(REG_COOLDOWN, CFG_DATA_W'(cool));
        write_reg(REG_TRANSITION, CFG_DATA_W'(glide));
        if (hue >= 0)
            write_reg(REG_START_HUE, CFG_DATA_W'(hue));
        write_reg(CFG_ADDR_W'($urandom_range(REG_START_HUE + 1, ADDR_TOP)),
                  CFG_DATA_W'($urandom));
        end_writes();
    endtask

    task automatic random_frames(input int count, input int dt_cap);
        logic [DT_W-1:0]  dt;
        logic [SAL_W-1:0] sal;
        logic             valid;
        int               pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
                dt = '0;
            else if (pick < 6)
                dt = '1;
            else if (pick < 16)
                dt = DT_W'($urandom);
            else
                dt = DT_W'($urandom_range(0, dt_cap));
            valid = ($urandom_range(0, 99) < 85);
            pick  = $urandom_range(0, 99);
            if (pick < 10)
                sal = SAL_W'($urandom);
            else if (pick < 55 || sb.thresh == '1)
                sal = SAL_W'($urandom_range(0, sb.thresh));
            else
                sal = SAL_W'($urandom_range(int'(sb.thresh) + 1, (1 << SAL_W) - 1));
            send_frame(dt, valid, sal);
            if (!calm && $urandom_range(0, 4) == 0)
                pause_sender($urandom_range(1, 16));
        end
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_addr      <= '0;
        cfg_wdata     <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults: rising crossing, cooldown block, cooldown saturation
        send_frame('0, 1'b1, '0);
        send_frame('0, 1'b1, '1);
        send_frame('1, 1'b1, '1);
        send_frame(DT_W'(1000), 1'b0, '0);
        send_frame('0, 1'b1, '0);
        send_frame('0, 1'b1, '1);
        send_frame('1, 1'b0, '1);
        send_frame(DT_W'(5), 1'b1, THRESHOLD_RESET);
        send_frame(DT_W'(5), 1'b1, THRESHOLD_RESET + SAL_W'(1));
        send_frame(DT_W'(10000), 1'b1, '0);

        // load the start hue mid-glide, then a half-turn shift
        drain();
        write_reg(REG_START_HUE, CFG_DATA_W'(200));
        write_reg(REG_HUE_SHIFT, CFG_DATA_W'(HUE_HALF));
        write_reg(REG_COOLDOWN, '0);
        write_reg(CFG_ADDR_W'(ADDR_TOP), '1);
        end_writes();
        send_frame('1, 1'b1, '0);
        send_frame('1, 1'b1, '1);
        send_frame(DT_W'(150000), 1'b1, '0);
        send_frame(DT_W'(150000), 1'b1, '0);

        // zero transition time
        drain();
        write_reg(REG_TRANSITION, '0);
        end_writes();
        send_frame(DT_W'(100), 1'b1, '1);
        send_frame('0, 1'b0, '1);
        send_frame(DT_W'(7), 1'b1, '1);

        set_glide_regs($urandom_range(1000, 60000), $urandom_range(0, 255), 50000, 200000, -1);
        random_frames(PHASE_ITEMS, 20000);
        set_glide_regs('0, '1, '0, 1, 0);
        random_frames(PHASE_ITEMS, 1000);
        set_glide_regs('1, HUE_HALF, '1, '1, -1);
        random_frames(PHASE_ITEMS / 2, 5000);
        set_glide_regs($urandom_range(1, 65534), HUE_HALF, $urandom_range(0, 100000), '1, 255);
        random_frames(PHASE_ITEMS, 20000);
        set_glide_regs($urandom_range(0, 65535), $urandom_range(0, 255),
                       $urandom_range(0, 400000), '0, -1);
        random_frames(PHASE_ITEMS, 50000);

        // long receiver hold while items keep coming
        set_glide_regs($urandom_range(0, 65535), $urandom_range(0, 255),
                       $urandom_range(0, 400000), $urandom_range(1, 1000000),
                       $urandom_range(0, 255));
        hold_long = 1'b1;
        random_frames(PHASE_ITEMS, 20000);

        set_glide_regs($urandom_range(0, 65535), $urandom_range(0, 255),
                       $urandom_range(0, 16777215), $urandom_range(1, 16777215), -1);
        random_frames(PHASE_ITEMS / 2, 20000);
        drain();
        random_frames(PHASE_ITEMS / 2, 20000);

        set_glide_regs($urandom_range(1000, 60000), $urandom_range(0, 255),
                       $urandom_range(0, 300000), $urandom_range(1, 600000), -1);
        calm = 1'b1;
        random_frames(PHASE_ITEMS, 20000);

        drain();
        repeat (50) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASS event_triggered_hue_glide");
        else
            $display("FAIL event_triggered_hue_glide");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL event_triggered_hue_glide");
        $finish;
    end

endmodule

FILE: filelist.f
sv/ethg_pkg.sv
sv/ethg_div.sv
sv/event_triggered_hue_glide.sv
sv/ethg_checker.sv
bench/tb_top.sv
